// ----- hw/rtl/twm_pkg.sv -----
// Shared types, codes and tables for the wavetable tone mixer.
`default_nettype none

package twm_pkg;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_NOTE = 2'd1;
    localparam logic [1:0] CMD_WAIT = 2'd2;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_NOTE = 2'd1;
    localparam logic [1:0] KIND_WAIT = 2'd2;
    localparam logic [1:0] KIND_MUTE = 2'd3;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [7:0] CLICKS_RESET = 8'd164;
    localparam logic [5:0] PHASE_IDX_MASK = 6'h3f;
    localparam logic [7:0] DUTY_OFFSET = 8'h80;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  channel;
        logic [15:0] data;
    } twm_entry_t;

    localparam logic signed [7:0] WAVE [64] = '{
           8'sd0,   8'sd20,   8'sd41,   8'sd60,   8'sd78,   8'sd93,  8'sd106,  8'sd116,
         8'sd123,  8'sd127,  8'sd127,  8'sd123,  8'sd117,  8'sd109,   8'sd98,   8'sd85,
          8'sd72,   8'sd57,   8'sd43,   8'sd28,   8'sd14,    8'sd3,   -8'sd5,  -8'sd14,
         -8'sd20,  -8'sd24,  -8'sd26,  -8'sd25,  -8'sd23,  -8'sd18,  -8'sd12,   -8'sd6,
           8'sd0,    8'sd6,   8'sd12,   8'sd18,   8'sd22,   8'sd25,   8'sd26,   8'sd25,
          8'sd20,   8'sd14,    8'sd6,   -8'sd2,  -8'sd14,  -8'sd28,  -8'sd42,  -8'sd57,
         -8'sd72,  -8'sd86,  -8'sd99, -8'sd109, -8'sd118, -8'sd124, -8'sd128, -8'sd128,
        -8'sd124, -8'sd117, -8'sd108,  -8'sd95,  -8'sd79,  -8'sd62,  -8'sd42,  -8'sd21
    };

    function automatic logic [7:0] base_step(input logic [3:0] semitone);
        logic [7:0] r;
        case (semitone)
            4'd0:    r = 8'd33;
            4'd1:    r = 8'd35;
            4'd2:    r = 8'd37;
            4'd3:    r = 8'd39;
            4'd4:    r = 8'd41;
            4'd5:    r = 8'd44;
            4'd6:    r = 8'd46;
            4'd7:    r = 8'd49;
            4'd8:    r = 8'd52;
            4'd9:    r = 8'd55;
            4'd10:   r = 8'd58;
            4'd11:   r = 8'd62;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/polyphonic_wavetable_tone_mixer.sv -----
// Top level of the polyphonic wavetable tone mixer.
//
//   channel  direction  ports                               beat carries
//   s_       in         s_valid/s_ready                     cmd, channel, value
//   m_       out        m_valid/m_ready                     duty, sound_on, event_due
//   cfg_     in         cfg_wr_en                           clicks_per_tick
//
// A note or wait beat is applied while the mixer is idle; a sample tick walks the channels
// through the single shared accumulator, which visits one channel per cycle.
// Input beats are taken while the four-entry command queue has room.
// The output register holds a result until it is taken; the mixer stalls only then.
// Reset is synchronous and active low; all channels come up silent.
`default_nettype none

module polyphonic_wavetable_tone_mixer #(
    parameter int NUM_CHANNELS     = 4,
    parameter int DURATION_DIVISOR = 2
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_cmd,
    input  wire logic [1:0] s_channel,
    input  wire logic [7:0] s_value,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_duty,
    output logic            m_sound_on,
    output logic            m_event_due
);
    import twm_pkg::*;

    logic       q_full;
    logic       q_push;
    twm_entry_t q_in;
    logic       q_valid;
    logic       q_pop;
    twm_entry_t q_out;

    twm_front #(
        .NUM_CHANNELS    (NUM_CHANNELS),
        .DURATION_DIVISOR(DURATION_DIVISOR)
    ) u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_cmd    (s_cmd),
        .s_channel(s_channel),
        .s_value  (s_value),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    twm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_entry(q_in),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_entry (q_out)
    );

    twm_back #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .q_valid    (q_valid),
        .q_entry    (q_out),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_duty     (m_duty),
        .m_sound_on (m_sound_on),
        .m_event_due(m_event_due)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/twm_front.sv -----
// Input decoder: classifies each beat and computes note steps and wait loads.
`default_nettype none

module twm_front #(
    parameter int NUM_CHANNELS     = 4,
    parameter int DURATION_DIVISOR = 2
) (
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_cmd,
    input  wire logic [1:0]         s_channel,
    input  wire logic [7:0]         s_value,
    input  wire logic               q_full,
    output logic                    q_push,
    output twm_pkg::twm_entry_t     q_entry
);
    import twm_pkg::*;

    localparam logic [16:0] DUR_M = 17'((65536 + DURATION_DIVISOR - 1) / DURATION_DIVISOR);

    logic        accept;
    logic        chan_ok;
    logic [15:0] oct_prod;
    logic [4:0]  octave;
    logic [7:0]  semitone;
    logic [15:0] base16;
    logic [15:0] note_step;
    logic [24:0] dur_prod;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign chan_ok = 5'(s_channel) < 5'(NUM_CHANNELS);

    // The octave is the value over twelve, by reciprocal multiplication.
    assign oct_prod  = 16'(s_value) * 16'd171;
    assign octave    = oct_prod[15:11];
    assign semitone  = s_value - 8'(8'(octave) * 8'd12);
    assign base16    = {8'd0, base_step(semitone[3:0])};
    assign note_step = (octave == 5'd0) ? 16'd0 : (base16 << (octave - 5'd1));

    assign dur_prod = 25'(s_value) * 25'(DUR_M);

    always_comb begin
        q_push          = 1'b0;
        q_entry.kind    = KIND_TICK;
        q_entry.channel = s_channel;
        q_entry.data    = 16'd0;
        case (s_cmd)
            CMD_TICK: begin
                q_push = accept;
            end
            CMD_NOTE: begin
                q_push       = accept && chan_ok;
                q_entry.kind = KIND_NOTE;
                q_entry.data = note_step;
            end
            CMD_WAIT: begin
                q_push       = accept;
                q_entry.kind = (s_value == 8'd0) ? KIND_MUTE : KIND_WAIT;
                q_entry.data = {8'd0, dur_prod[23:16]};
            end
            default: begin
                q_push = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/twm_queue.sv -----
// Short command queue between the decoder and the mixer.
`default_nettype none

module twm_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire twm_pkg::twm_entry_t push_entry,
    output logic                     full,
    output logic                     pop_valid,
    input  wire logic                pop,
    output twm_pkg::twm_entry_t      pop_entry
);
    import twm_pkg::*;

    twm_entry_t        entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = count_reg == (QPTR_W + 1)'(QDEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_entry = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("queue written while full");

endmodule

`default_nettype wire

// ----- hw/rtl/twm_back.sv -----
// Mixer: applies queued commands, walks the channels per tick and drives results.
`default_nettype none

module twm_back #(
    parameter int NUM_CHANNELS = 4
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [7:0]          cfg_wr_data,
    input  wire logic                q_valid,
    input  wire twm_pkg::twm_entry_t q_entry,
    output logic                     q_pop,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [7:0]               m_duty,
    output logic                     m_sound_on,
    output logic                     m_event_due
);
    import twm_pkg::*;

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SUM_W  = $clog2(NUM_CHANNELS) + 9;
    localparam int PROD_W = SUM_W + 17;
    localparam logic [16:0] DIV_M = 17'((65536 + NUM_CHANNELS - 1) / NUM_CHANNELS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MIX  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]              state_reg;
    logic [15:0]             step_reg [NUM_CHANNELS];
    logic [15:0]             phase_reg [NUM_CHANNELS];
    logic [CH_W-1:0]         idx_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [7:0]              wait_reg;
    logic [7:0]              click_reg;
    logic                    audio_reg;
    logic [7:0]              cpt_reg;
    logic                    m_valid_reg;
    logic [7:0]              duty_reg;
    logic                    sound_reg;
    logic                    due_reg;

    logic [CH_W-1:0]         note_idx;
    logic [15:0]             cur_step;
    logic [15:0]             cur_phase;
    logic signed [7:0]       cur_wave;
    logic                    out_load;
    logic                    neg;
    logic [SUM_W-1:0]        mag;
    logic [PROD_W-1:0]       prod;
    logic [SUM_W-1:0]        quo;
    logic [SUM_W-1:0]        mixed;
    logic [7:0]              click_inc;
    logic                    tick_roll;
    logic [7:0]              wait_next;

    assign note_idx  = CH_W'(q_entry.channel);
    assign cur_step  = step_reg[idx_reg];
    assign cur_phase = phase_reg[idx_reg];
    assign cur_wave  = WAVE[cur_phase[13:8] & PHASE_IDX_MASK];
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    assign neg   = sum_reg[SUM_W-1];
    assign mag   = neg ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign prod  = PROD_W'(mag) * PROD_W'(DIV_M);
    assign quo   = prod[16 +: SUM_W];
    assign mixed = neg ? SUM_W'(-quo) : quo;

    assign click_inc = click_reg + 8'd1;
    assign tick_roll = click_inc >= cpt_reg;
    assign wait_next = (tick_roll && wait_reg != 8'd0) ? wait_reg - 8'd1 : wait_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            wait_reg    <= 8'd0;
            click_reg   <= 8'd0;
            audio_reg   <= 1'b1;
            cpt_reg     <= CLICKS_RESET;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                step_reg[i]  <= 16'd0;
                phase_reg[i] <= 16'd0;
            end
        end else begin
            if (cfg_wr_en) begin
                cpt_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        case (q_entry.kind)
                            KIND_NOTE: step_reg[note_idx] <= q_entry.data;
                            KIND_WAIT: wait_reg <= q_entry.data[7:0];
                            KIND_MUTE: audio_reg <= 1'b0;
                            default: begin
                                idx_reg   <= '0;
                                state_reg <= ST_MIX;
                            end
                        endcase
                    end
                end
                ST_MIX: begin
                    if (cur_step != 16'd0) begin
                        phase_reg[idx_reg] <= cur_phase + cur_step;
                    end
                    if (idx_reg == CH_W'(NUM_CHANNELS - 1)) begin
                        state_reg <= ST_DONE;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        wait_reg  <= wait_next;
                        click_reg <= tick_roll ? 8'd0 : click_inc;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE) begin
            sum_reg <= '0;
        end else if (state_reg == ST_MIX && cur_step != 16'd0) begin
            sum_reg <= sum_reg + SUM_W'(cur_wave);
        end
        if (out_load) begin
            duty_reg  <= mixed[7:0] + DUTY_OFFSET;
            sound_reg <= audio_reg;
            due_reg   <= wait_next == 8'd0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_duty      = duty_reg;
    assign m_sound_on  = sound_reg;
    assign m_event_due = due_reg;

    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == ST_IDLE))
        else $error("queue popped while a tick is in progress");

    a_mix_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MIX) |=> (state_reg == ST_MIX || state_reg == ST_DONE))
        else $error("channel walk left early");

    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !out_load) |=> (state_reg == ST_DONE && m_valid_reg))
        else $error("finished tick dropped while output stalled");

endmodule

`default_nettype wire
